// ===== rtl/mjm_pkg.sv =====
`default_nettype none

package mjm_pkg;

   // field widths
   localparam int HASH_W     = 16;
   localparam int LEN_W      = 11;
   localparam int INTER_W    = 11;
   localparam int UNION_W    = 12;
   localparam int SIM_W      = 20;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - INTER_W - UNION_W - 1 - SIM_W;

   // scaled ratio arithmetic
   localparam int PROD_W    = 31;
   localparam int DIV_STEPS = PROD_W;
   localparam int DCNT_W    = 5;
   localparam int TEN_W     = INTER_W + 4;

   localparam logic [SIM_W-1:0] SIM_SCALE = 20'd1000000;
   localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

   // controller to datapath
   typedef struct packed {
      logic load_we;
      logic start;
      logic merge_step;
      logic mult;
      logic div_step;
      logic emit;
   } mjm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_item;
      logic merge_done;
      logic div_last;
      logic out_free;
   } mjm_sts_type;

endpackage

`default_nettype wire

// ===== rtl/mjm_ctrl.sv =====
`default_nettype none

module mjm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire mjm_pkg::mjm_sts_type sts,
   output mjm_pkg::mjm_cmd_type      cmd
);
   import mjm_pkg::*;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_PRIME = 6'b000010,
      ST_MERGE = 6'b000100,
      ST_MULT  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.load_we    = accept;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && sts.last_item) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            cmd.start = 1'b1;
            state_in  = ST_MERGE;
         end
         ST_MERGE: begin
            if (sts.merge_done) begin
               state_in = ST_MULT;
            end else begin
               cmd.merge_step = 1'b1;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mjm_dpath.sv =====
`default_nettype none

module mjm_dpath #(
   parameter int MAX_SKETCH_LEN = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [mjm_pkg::LEN_W-1:0]      csr_wdata,
   input  wire logic [mjm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [mjm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire mjm_pkg::mjm_cmd_type           cmd,
   output mjm_pkg::mjm_sts_type                sts
);
   import mjm_pkg::*;

   localparam int AW = $clog2(MAX_SKETCH_LEN);

   // sketch stores, no reset: only slots loaded since the last merge are read
   logic signed [HASH_W-1:0] mem_a [MAX_SKETCH_LEN];
   logic signed [HASH_W-1:0] mem_b [MAX_SKETCH_LEN];

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   load_idx_ff, load_idx_in;
   logic [LEN_W-1:0]   merge_n_ff, merge_n_in;
   logic [LEN_W-1:0]   n_eff;
   logic [LEN_W-1:0]   slot;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;

   logic signed [HASH_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [HASH_W-1:0] hash_a, hash_b;

   logic [LEN_W-1:0]   ia_ff, ia_in, ib_ff, ib_in;
   logic [INTER_W-1:0] inter_ff, inter_in;
   logic [UNION_W-1:0] uni_ff, uni_in;
   logic               a_live, b_live;

   logic [PROD_W-1:0]  dq_ff, dq_in;
   logic [UNION_W-1:0] rem_ff, rem_in;
   logic [UNION_W:0]   rem_sh;
   logic               div_ge;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic [TEN_W-1:0]   inter_x10;
   logic               passes;
   logic [SIM_W-1:0]   sim;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign hash_a = req_tdata[HASH_W-1:0];
   assign hash_b = req_tdata[2*HASH_W-1:HASH_W];

   // length clamp to one .. store depth
   always_comb begin
      if (len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (32'(len_ff) > 32'(MAX_SKETCH_LEN)) begin
         n_eff = LEN_W'(MAX_SKETCH_LEN);
      end else begin
         n_eff = len_ff;
      end
      if (32'(load_idx_ff) >= 32'(MAX_SKETCH_LEN)) begin
         slot = LEN_W'(MAX_SKETCH_LEN - 1);
      end else begin
         slot = load_idx_ff;
      end
   end

   assign wr_addr       = AW'(slot);
   assign sts.last_item = (slot >= n_eff - LEN_W'(1));

   always_comb begin
      load_idx_in = load_idx_ff;
      merge_n_in  = merge_n_ff;
      if (cmd.load_we) begin
         if (sts.last_item) begin
            load_idx_in = '0;
            merge_n_in  = slot + LEN_W'(1);
         end else begin
            load_idx_in = slot + LEN_W'(1);
         end
      end
   end

   // two-pointer merge, one step per cycle, tails handled by the same step
   assign a_live = (ia_ff < merge_n_ff);
   assign b_live = (ib_ff < merge_n_ff);
   assign sts.merge_done = !a_live && !b_live;

   always_comb begin
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      inter_in = inter_ff;
      uni_in   = uni_ff;
      if (cmd.start) begin
         ia_in    = '0;
         ib_in    = '0;
         inter_in = '0;
         uni_in   = '0;
      end else if (cmd.merge_step) begin
         if (a_live && b_live) begin
            if (rd_a_ff == rd_b_ff) begin
               if (rd_a_ff != '0) begin
                  inter_in = inter_ff + INTER_W'(1);
                  uni_in   = uni_ff + UNION_W'(1);
               end
               ia_in = ia_ff + LEN_W'(1);
               ib_in = ib_ff + LEN_W'(1);
            end else if (rd_a_ff == '0 || (rd_b_ff != '0 && rd_a_ff > rd_b_ff)) begin
               uni_in = uni_ff + UNION_W'(1);
               ib_in  = ib_ff + LEN_W'(1);
            end else begin
               uni_in = uni_ff + UNION_W'(1);
               ia_in  = ia_ff + LEN_W'(1);
            end
         end else if (a_live) begin
            if (rd_a_ff != '0) begin
               uni_in = uni_ff + UNION_W'(1);
            end
            ia_in = ia_ff + LEN_W'(1);
         end else if (b_live) begin
            if (rd_b_ff != '0) begin
               uni_in = uni_ff + UNION_W'(1);
            end
            ib_in = ib_ff + LEN_W'(1);
         end
      end
   end

   // read ahead at the next pointer so data lines up with the pointer register
   assign rd_addr = AW'(ia_in);

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         mem_a[wr_addr] <= hash_a;
         mem_b[wr_addr] <= hash_b;
      end
      rd_a_ff <= mem_a[rd_addr];
      rd_b_ff <= mem_b[AW'(ib_in)];
   end

   // restoring divide, one quotient bit per cycle, quotient shifts into dq
   assign rem_sh = {rem_ff, dq_ff[PROD_W-1]};
   assign div_ge = (rem_sh >= {1'b0, uni_ff});
   assign sts.div_last = (dcnt_ff == DCNT_W'(DIV_STEPS - 1));

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.mult) begin
         dq_in   = PROD_W'(inter_ff) * PROD_W'(SIM_SCALE);
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         dq_in   = {dq_ff[PROD_W-2:0], div_ge};
         rem_in  = div_ge ? UNION_W'(rem_sh - {1'b0, uni_ff}) : UNION_W'(rem_sh);
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   assign inter_x10 = {1'b0, inter_ff, 3'b000} + {3'b000, inter_ff, 1'b0};
   assign passes    = (uni_ff != '0) && (inter_x10 > TEN_W'(uni_ff));
   assign sim       = (uni_ff == '0) ? '0 : dq_ff[SIM_W-1:0];

   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         load_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         load_idx_ff  <= load_idx_in;
         rsp_valid_ff <= cmd.emit || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      merge_n_ff <= merge_n_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      inter_ff   <= inter_in;
      uni_ff     <= uni_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      dcnt_ff    <= dcnt_in;
      if (cmd.emit) begin
         rsp_data_ff <= {RSP_PAD_W'(0), sim, passes, uni_ff, inter_ff};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/minhash_jaccard_merge.sv =====
// sequence: after the item that completes a sketch pair the block primes the store reads,
//   merges (n .. 2n merge steps for n slots), multiplies, divides and shows the result
// merge is one step per cycle, set by the single read port of each sketch store; no
//   new item is accepted until the result of a sketch pair has been shown
// reset: synchronous active high, length goes to 1024, load index to zero, no result
//   pending; sketch stores are not cleared and need no clearing pass
`default_nettype none

module minhash_jaccard_merge #(
   parameter int MAX_SKETCH_LEN = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration: sketch_length
   input  wire logic                           csr_we,
   input  wire logic [mjm_pkg::LEN_W-1:0]      csr_wdata,
   // input items
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // hash_a[15:0], hash_b[31:16]
   input  wire logic [mjm_pkg::REQ_DATA_W-1:0] req_tdata,
   // result items
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // intersection_count[10:0], union_size[22:11], passes[23],
   // similarity_scaled[43:24], zero pad[47:44]
   output logic [mjm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import mjm_pkg::*;

   mjm_cmd_type cmd;
   mjm_sts_type sts;

   // sequencer: load, prime the store reads, merge, multiply, divide, emit
   mjm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // sketch stores, merge counters, divider and output register
   mjm_dpath #(
      .MAX_SKETCH_LEN (MAX_SKETCH_LEN)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

// ===== rtl/mjm_checker.sv =====
`default_nettype none

module mjm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [mjm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mjm_pkg::*;

   logic [INTER_W-1:0] inter;
   logic [UNION_W-1:0] uni;
   logic               passes;
   logic [SIM_W-1:0]   sim;

   assign inter  = rsp_tdata[INTER_W-1:0];
   assign uni    = rsp_tdata[INTER_W+UNION_W-1:INTER_W];
   assign passes = rsp_tdata[INTER_W+UNION_W];
   assign sim    = rsp_tdata[INTER_W+UNION_W+SIM_W:INTER_W+UNION_W+1];

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // every match is also counted in the union
   a_inter_le_union: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, inter} <= uni)
      else $error("intersection exceeds union");

   // empty union gives no pass and zero similarity
   a_empty_union: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && uni == '0 |-> !passes && sim == '0)
      else $error("empty union with nonzero score");

   // ratio never above one
   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> sim <= SIM_SCALE)
      else $error("similarity above full scale");

endmodule

bind minhash_jaccard_merge mjm_checker u_mjm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/jaccard_merge_checker.sv =====
module jaccard_merge_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [mjm_pkg::LEN_W-1:0]      csr_wdata,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   // hash_a[15:0], hash_b[31:16]
   input  wire logic [mjm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // intersection_count[10:0], union_size[22:11], passes[23],
   // similarity_scaled[43:24], zero pad[47:44]
   input  wire logic [mjm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                                  mismatch_count,
   output int                                  scores_awaited
);

   import mjm_pkg::*;

   localparam int MAX_SLOTS = 1024;

   typedef struct {
      logic [INTER_W-1:0] inter;
      logic [UNION_W-1:0] uni;
      logic               passes;
      logic [SIM_W-1:0]   sim;
   } jaccard_score_type;

   logic [LEN_W-1:0]         length_reg;
   logic signed [HASH_W-1:0] slots_a [MAX_SLOTS];
   logic signed [HASH_W-1:0] slots_b [MAX_SLOTS];
   int unsigned              fill_index;
   int unsigned              used_len;
   jaccard_score_type        awaited_scores [$];
   jaccard_score_type        got_score;
   jaccard_score_type        want_score;

   initial begin
      mismatch_count = 0;
      scores_awaited = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // two-pointer walk over the first n slots of both sketches
   function automatic jaccard_score_type score_sketches(input int unsigned n);
      int unsigned       ia;
      int unsigned       ib;
      int unsigned       inter;
      int unsigned       uni;
      jaccard_score_type s;
      ia = 0;
      ib = 0;
      inter = 0;
      uni = 0;
      while (ia < n && ib < n) begin
         if (slots_a[ia] == slots_b[ib]) begin
            if (slots_a[ia] != 0) begin
               inter++;
               uni++;
            end
            ia++;
            ib++;
         end else if (slots_a[ia] == 0 || (slots_b[ib] != 0 && slots_a[ia] > slots_b[ib])) begin
            uni++;
            ib++;
         end else begin
            uni++;
            ia++;
         end
      end
      for (; ia < n; ia++)
         if (slots_a[ia] != 0)
            uni++;
      for (; ib < n; ib++)
         if (slots_b[ib] != 0)
            uni++;
      s.inter  = inter[INTER_W-1:0];
      s.uni    = uni[UNION_W-1:0];
      s.passes = (uni > 0 && 10 * inter > uni);
      s.sim    = (uni > 0) ? SIM_W'((longint'(inter) * SIM_SCALE) / uni) : '0;
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         length_reg = LEN_RESET;
         fill_index = 0;
         awaited_scores.delete();
      end else begin
         // results first: one accepted now belongs to an older sketch pair
         if (rsp_tvalid && rsp_tready) begin
            got_score.inter  = rsp_tdata[INTER_W-1:0];
            got_score.uni    = rsp_tdata[INTER_W +: UNION_W];
            got_score.passes = rsp_tdata[INTER_W+UNION_W];
            got_score.sim    = rsp_tdata[INTER_W+UNION_W+1 +: SIM_W];
            if (awaited_scores.size() == 0) begin
               report_mismatch("result item with no score pending");
            end else begin
               want_score = awaited_scores.pop_front();
               compare_field("intersection_count", got_score.inter, want_score.inter);
               compare_field("union_size", got_score.uni, want_score.uni);
               compare_field("passes", got_score.passes, want_score.passes);
               compare_field("similarity_scaled", got_score.sim, want_score.sim);
            end
         end
         if (csr_we)
            length_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            used_len = (length_reg == 0) ? 1
                     : ((length_reg > MAX_SLOTS) ? MAX_SLOTS : length_reg);
            if (fill_index >= MAX_SLOTS)
               fill_index = MAX_SLOTS - 1;
            slots_a[fill_index] = req_tdata[HASH_W-1:0];
            slots_b[fill_index] = req_tdata[HASH_W +: HASH_W];
            if (fill_index + 1 >= used_len) begin
               awaited_scores.insert(awaited_scores.size(), score_sketches(fill_index + 1));
               fill_index = 0;
            end else begin
               fill_index++;
            end
         end
      end
      scores_awaited = awaited_scores.size();
   end

endmodule

// ===== bench/minhash_jaccard_merge_test.sv =====
module minhash_jaccard_merge_test;

   import mjm_pkg::*;

   // block ports, all known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [LEN_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   // hash_a[15:0], hash_b[31:16]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // intersection_count[10:0], union_size[22:11], passes[23],
   // similarity_scaled[43:24], zero pad[47:44]
   wire [RSP_DATA_W-1:0]  rsp_tdata;

   // from the checker
   int mismatch_count;
   int scores_awaited;

   // stimulus bookkeeping
   int items_sent    = 0;
   int sketches_done = 0;
   int slots_in_use  = 1024;
   int gap_pct       = 0;
   int stall_pct     = 0;
   int stall_left    = 0;
   bit no_idle       = 1'b0;
   bit big_done      = 1'b0;
   int sk_a [$];
   int sk_b [$];

   minhash_jaccard_merge dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   jaccard_merge_checker score_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .scores_awaited (scores_awaited)
   );

   // period of 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure: random stall bursts
   always @(negedge clock) begin
      if (no_idle || stall_pct == 0) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         // this cycle is the first of the burst
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one slot pair per item; entered and left at a falling edge with valid still high,
   // so back-to-back items drop valid in between only when a random gap is taken
   task automatic send_pair(input logic [HASH_W-1:0] a, input logic [HASH_W-1:0] b);
      if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // block idle: every score back, then a short pause for a load still in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (scores_awaited != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_length(input int v);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= v[LEN_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      // zero acts as one, anything above the store depth saturates
      slots_in_use = (v == 0) ? 1 : ((v > 1024) ? 1024 : v);
   endtask

   // well-formed pair: ascending nonzero hashes with a random share in common,
   // zero padding when the values run out, sometimes a zeroed tail
   task automatic build_sorted(input int n);
      int share;
      int max_step;
      int cur;
      int trim;
      bit to_a;
      sk_a.delete();
      sk_b.delete();
      share    = $urandom_range(0, 100);
      max_step = 65535 / (3 * n);
      if (max_step > 2000)
         max_step = 2000;
      cur = -32768 + int'($urandom_range(0, 65535 - 2 * n * max_step));
      while ((sk_a.size() < n || sk_b.size() < n) && cur <= 32767) begin
         if (cur != 0) begin
            if ($urandom_range(0, 99) < share) begin
               if (sk_a.size() < n)
                  sk_a.insert(sk_a.size(), cur);
               if (sk_b.size() < n)
                  sk_b.insert(sk_b.size(), cur);
            end else begin
               to_a = $urandom_range(0, 1);
               if (sk_a.size() >= n)
                  to_a = 1'b0;
               if (sk_b.size() >= n)
                  to_a = 1'b1;
               if (to_a)
                  sk_a.insert(sk_a.size(), cur);
               else
                  sk_b.insert(sk_b.size(), cur);
            end
         end
         cur += $urandom_range(1, max_step);
      end
      while (sk_a.size() < n) sk_a.insert(sk_a.size(), 0);
      while (sk_b.size() < n) sk_b.insert(sk_b.size(), 0);
      if ($urandom_range(0, 2) == 0) begin
         trim = $urandom_range(0, n / 4);
         for (int i = n - trim; i < n; i++) sk_a[i] = 0;
      end
      if ($urandom_range(0, 2) == 0) begin
         trim = $urandom_range(0, n / 4);
         for (int i = n - trim; i < n; i++) sk_b[i] = 0;
      end
   endtask

   // unsorted noise over the whole 16-bit range, with scattered empty slots
   task automatic build_noise(input int n);
      int v;
      sk_a.delete();
      sk_b.delete();
      for (int i = 0; i < n; i++) begin
         v = $urandom_range(0, 65535);
         sk_a.insert(sk_a.size(), ($urandom_range(0, 7) == 0) ? 0 : v);
         v = $urandom_range(0, 65535);
         sk_b.insert(sk_b.size(), ($urandom_range(0, 7) == 0) ? 0 : v);
      end
   endtask

   task automatic send_sketch();
      for (int i = 0; i < slots_in_use; i++)
         send_pair(sk_a[i][HASH_W-1:0], sk_b[i][HASH_W-1:0]);
      sketches_done++;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, with some idling on both sides
      gap_pct   = 20;
      stall_pct = 10;

      // single-slot sketches: empty union, extremes, a zero against nonzero on each side
      set_length(1);
      send_pair(16'h0000, 16'h0000);
      send_pair(16'h7FFF, 16'h7FFF);
      send_pair(16'h8000, 16'h7FFF);
      send_pair(16'h0001, 16'h0000);
      send_pair(16'h0000, 16'hFFFF);
      send_pair(16'h8000, 16'h8000);

      // length zero behaves as one
      set_length(0);
      send_pair(16'h0005, 16'h0005);

      // short sorted pair with a shared head, a gap and a trailing empty slot
      set_length(4);
      send_pair(-16'sd100, -16'sd100);
      send_pair(-16'sd5, 16'sd3);
      send_pair(16'sd3, 16'sd7);
      send_pair(16'sd40, 16'sd0);

      // length lowered below the load index: the next item closes the sketch at 6 slots
      set_length(8);
      for (int i = 0; i < 5; i++) send_pair(16'(i * 7 + 1), 16'(i * 5 + 1));
      set_length(3);
      send_pair(16'sd50, 16'sd50);

      // length changed mid-load but still ahead of the load index
      set_length(8);
      for (int i = 0; i < 2; i++) send_pair(16'(i * 3 + 2), 16'(i * 3 + 2));
      set_length(6);
      for (int i = 0; i < 4; i++) send_pair(16'(i * 9 + 10), 16'(i * 4 + 10));

      // random part: mostly small sorted sketches, one full-depth one, some noise
      while (items_sent < 1150) begin
         if (!big_done && items_sent >= 60) begin
            // register all ones, saturates to the store depth
            set_length(2047);
            big_done = 1'b1;
         end else if (sketches_done == 0 || slots_in_use > 64 || $urandom_range(0, 99) < 30) begin
            set_length(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16));
         end
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 30;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 5;
            default: stall_pct = 20;
         endcase
         // tail of the run goes at full rate on both sides
         no_idle = big_done && items_sent >= 1050;
         if ($urandom_range(0, 4) == 0)
            build_noise(slots_in_use);
         else
            build_sorted(slots_in_use);
         send_sketch();
      end

      // drain, then leave room for a stray result to show up
      req_tvalid <= 1'b0;
      while (scores_awaited != 0) @(negedge clock);
      repeat (64) @(negedge clock);
      if (mismatch_count == 0 && scores_awaited == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mjm_pkg.sv
rtl/mjm_ctrl.sv
rtl/mjm_dpath.sv
rtl/minhash_jaccard_merge.sv
rtl/mjm_checker.sv
bench/jaccard_merge_checker.sv
bench/minhash_jaccard_merge_test.sv
